/* design/sha_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last_word;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} out_beat_t;

	// Work unit handed from front to back: a word to place in the block buffer.
	typedef struct packed {
		logic [31:0] word;
		logic [3:0]  pos;
		logic        compress;  // compress after writing this word
		logic        emit;      // emit digest after that compression
	} job_t;

	localparam int QueueDepth = 4;
	localparam int QueueAw    = 2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		round_k = k[i];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		init_h = h[i];
	endfunction

endpackage
`default_nettype wire

/* design/sha_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message beats, pads the last one, tracks the length and issues
// block-buffer writes to the back end queue.
// ----------------------------------------------------------------------------
module sha_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sha_pkg::in_beat_t in_beat,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output sha_pkg::job_t         job,
	output logic                  job_valid,
	input  wire logic             job_full
);
	import sha_pkg::*;

	typedef enum logic [2:0] {
		S_TAKE, S_EXTRA, S_ZERO, S_LEN_HI, S_LEN_LO
	} state_t;

	state_t      state_q;
	logic [60:0] bytes_q;
	logic [3:0]  pos_q;
	logic [63:0] bits;
	logic [2:0]  cnt;
	logic [31:0] keep;
	logic [31:0] padded;
	logic [60:0] nbytes;

	assign bits = {bytes_q, 3'b000};
	assign in_stall = (state_q != S_TAKE) || job_full;

	always_comb begin
		cnt = (in_beat.byte_count > 3'd4) ? 3'd4 : in_beat.byte_count;
		if (!in_beat.last_word)
			cnt = 3'd4;
		unique case (cnt)
			3'd0: keep = 32'h0000_0000;
			3'd1: keep = 32'hff00_0000;
			3'd2: keep = 32'hffff_0000;
			3'd3: keep = 32'hffff_ff00;
			default: keep = 32'hffff_ffff;
		endcase
		unique case (cnt)
			3'd0: padded = 32'h8000_0000;
			3'd1: padded = (in_beat.data_word & keep) | 32'h0080_0000;
			3'd2: padded = (in_beat.data_word & keep) | 32'h0000_8000;
			3'd3: padded = (in_beat.data_word & keep) | 32'h0000_0080;
			default: padded = in_beat.data_word;
		endcase
		nbytes = bytes_q + {58'd0, cnt};
	end

	always_comb begin
		job = '0;
		job_valid = 1'b0;
		unique case (state_q)
			S_TAKE: begin
				job_valid = in_valid;
				job.word = padded;
				job.pos = pos_q;
				if (!in_beat.last_word) begin
					job.compress = (pos_q == 4'd15);
				end else if (cnt == 3'd4) begin
					job.compress = (pos_q == 4'd15);
				end else begin
					job.compress = (pos_q == 4'd15);
				end
			end
			S_EXTRA: begin
				job_valid = 1'b1;
				job.word = 32'h8000_0000;
				job.pos = pos_q;
				job.compress = (pos_q == 4'd15);
			end
			S_ZERO: begin
				job_valid = 1'b1;
				job.word = '0;
				job.pos = pos_q;
				job.compress = (pos_q == 4'd15);
			end
			S_LEN_HI: begin
				job_valid = 1'b1;
				job.word = bits[63:32];
				job.pos = 4'd14;
			end
			default: begin
				job_valid = 1'b1;
				job.word = bits[31:0];
				job.pos = 4'd15;
				job.compress = 1'b1;
				job.emit = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
			bytes_q <= '0;
			pos_q <= '0;
		end else if (!job_full) begin
			unique case (state_q)
				S_TAKE: begin
					if (in_valid) begin
						bytes_q <= nbytes;
						pos_q <= pos_q + 4'd1;
						if (in_beat.last_word) begin
							if (cnt == 3'd4)
								state_q <= S_EXTRA;
							else if (pos_q == 4'd13)
								state_q <= S_LEN_HI;
							else
								state_q <= S_ZERO;
						end
					end
				end
				S_EXTRA: begin
					pos_q <= pos_q + 4'd1;
					state_q <= (pos_q == 4'd13) ? S_LEN_HI : S_ZERO;
				end
				S_ZERO: begin
					pos_q <= pos_q + 4'd1;
					if (pos_q == 4'd13)
						state_q <= S_LEN_HI;
				end
				S_LEN_HI: begin
					state_q <= S_LEN_LO;
				end
				default: begin
					state_q <= S_TAKE;
					pos_q <= '0;
					bytes_q <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/sha_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 job queue
// Short FIFO between the front end and the compression back end.
// ----------------------------------------------------------------------------
module sha_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sha_pkg::job_t wr_job,
	input  wire logic          wr_en,
	output logic               full,
	output sha_pkg::job_t      rd_job,
	output logic               rd_valid,
	input  wire logic          rd_en
);
	import sha_pkg::*;

	job_t               mem_q [QueueDepth];
	logic [QueueAw-1:0] wp_q;
	logic [QueueAw-1:0] rp_q;
	logic [QueueAw:0]   cnt_q;
	logic               push;
	logic               pop;

	assign full = (cnt_q == (QueueAw+1)'(QueueDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_job = mem_q[rp_q];
	assign push = wr_en && !full;
	assign pop = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + 1'b1;
			if (pop)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
		end
	end

endmodule
`default_nettype wire

/* design/sha_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression back end
// Writes block words, runs 64 rounds per block, one round per cycle, and
// emits the digest words through an output register.
// ----------------------------------------------------------------------------
module sha_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha_pkg::job_t     job,
	input  wire logic              job_valid,
	output logic                   job_take,
	output sha_pkg::out_beat_t     out_beat,
	output logic                   out_valid,
	input  wire logic              out_stall
);
	import sha_pkg::*;

	typedef enum logic [1:0] {S_LOAD, S_ROUND, S_ADD, S_EMIT} state_t;

	state_t      state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  rnd_q;
	logic        emit_q;
	logic [2:0]  idx_q;
	logic [31:0] wt;
	logic [31:0] wnew;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] s0;
	logic [31:0] s1;

	assign job_take = (state_q == S_LOAD) && job_valid;

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		wt = w_q[0];
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + wt;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			w_q[job.pos] <= job.word;
		end else if (state_q == S_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			rnd_q <= '0;
			emit_q <= 1'b0;
			idx_q <= '0;
			out_valid <= 1'b0;
			out_beat <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= init_h(3'(i));
				v_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (job_valid && job.compress) begin
						emit_q <= job.emit;
						rnd_q <= '0;
						for (int i = 0; i < 8; i++)
							v_q[i] <= h_q[i];
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						state_q <= S_ADD;
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
					idx_q <= '0;
					state_q <= emit_q ? S_EMIT : S_LOAD;
				end
				default: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_beat.digest_word <= h_q[idx_q];
						out_beat.word_index <= idx_q;
						out_beat.digest_last <= (idx_q == 3'd7);
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								h_q[i] <= init_h(3'(i));
							state_q <= S_LOAD;
						end
					end
				end
			endcase
			if (state_q != S_EMIT && out_valid && !out_stall)
				out_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* design/sha256_stream_hasher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Each 16-word block costs 16 block-buffer writes plus a compression loop of
// 64 rounds, one round per cycle, and one add; the core takes no words meanwhile.
// From the last word to the first digest beat lie up to two compressions plus
// the padding writes; digest beats then leave one per cycle while out_stall is low.
// Reset: hash returns to the initial values, length and queue clear.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sha_pkg::in_beat_t  in_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output sha_pkg::out_beat_t      out_data,
	output logic                    out_valid,
	input  wire logic               out_stall
);
	import sha_pkg::*;

	job_t f_job;
	logic f_valid;
	logic q_full;
	job_t q_job;
	logic q_valid;
	logic q_take;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .in_beat(in_data), .in_valid(in_valid),
		.in_stall(in_stall), .job(f_job), .job_valid(f_valid), .job_full(q_full)
	);

	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_job(f_job), .wr_en(f_valid),
		.full(q_full), .rd_job(q_job), .rd_valid(q_valid), .rd_en(q_take)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .job(q_job), .job_valid(q_valid),
		.job_take(q_take), .out_beat(out_data), .out_valid(out_valid),
		.out_stall(out_stall)
	);

endmodule
`default_nettype wire
